>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the card list engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("card list engine assertion failed");

// Clocked assertion that is also checked during reset.
`define CLE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("card list engine reset assertion failed");

`endif

>>> rtl/core/cle_pkg.sv
// ----------------------------------------------------------------------------
// Card list engine package
// Field widths, command and status codes, state and control types.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int DECK_DEPTH_DEF = 64;

    localparam int CMD_W     = 3;
    localparam int RANK_W    = 4;
    localparam int SUIT_W    = 2;
    localparam int CARD_W    = RANK_W + SUIT_W;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_POP    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_COUNT  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic pop_take;
        logic scan_rd;
        logic scan_chk;
        logic out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             scan_last;
        logic             out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/cle_ifs.sv
// ----------------------------------------------------------------------------
// Card list engine channels
// Command and response channels with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface cle_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cle_pkg::CMD_W-1:0]   cmd;
    logic [cle_pkg::RANK_W-1:0]  card_rank;
    logic [cle_pkg::SUIT_W-1:0]  card_suit;

    modport source (output valid, output cmd, output card_rank, output card_suit,
                    input ready);
    modport sink (input valid, input cmd, input card_rank, input card_suit,
                  output ready);
endinterface

interface cle_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cle_pkg::RANK_W-1:0]     popped_rank;
    logic [cle_pkg::SUIT_W-1:0]     front_suit;
    logic [cle_pkg::CNT_OUT_W-1:0]  suit_total;
    logic [cle_pkg::CNT_OUT_W-1:0]  list_length;
    logic [cle_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output popped_rank, output front_suit,
                    output suit_total, output list_length, output status,
                    input ready);
    modport sink (input valid, input popped_rank, input front_suit,
                  input suit_total, input list_length, input status,
                  output ready);
endinterface

>>> rtl/core/cle_ctrl.sv
// ----------------------------------------------------------------------------
// Card list engine controller
// Sequences one command at a time through execute, pop, scan and result.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cle_pkg::t_dp_stat   i_stat,
    output cle_pkg::t_dp_ctrl   o_ctrl
);

    cle_pkg::t_state r_state;
    cle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = cle_pkg::S_EXEC;
                end
            end
            cle_pkg::S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = cle_pkg::S_DONE;
                unique case (cle_pkg::t_cmd'(i_stat.cmd)) inside
                    cle_pkg::CMD_POP: begin
                        if (!i_stat.empty) begin
                            n_state = cle_pkg::S_POP;
                        end
                    end
                    cle_pkg::CMD_REMOVE, cle_pkg::CMD_COUNT: begin
                        if (!i_stat.empty) begin
                            n_state = cle_pkg::S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = cle_pkg::S_DONE;
                    end
                endcase
            end
            cle_pkg::S_POP: begin
                o_ctrl.pop_take = 1'b1;
                n_state         = cle_pkg::S_DONE;
            end
            cle_pkg::S_SCAN_RD: begin
                o_ctrl.scan_rd = 1'b1;
                n_state        = cle_pkg::S_SCAN_CHK;
            end
            cle_pkg::S_SCAN_CHK: begin
                o_ctrl.scan_chk = 1'b1;
                n_state = i_stat.scan_last ? cle_pkg::S_DONE : cle_pkg::S_SCAN_RD;
            end
            cle_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = cle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/cle_datapath.sv
// ----------------------------------------------------------------------------
// Card list engine datapath
// Circular card store, head and length registers, scan unit and result register.
// ----------------------------------------------------------------------------
module cle_datapath #(
    parameter int DECK_DEPTH = cle_pkg::DECK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cle_pkg::t_dp_ctrl                i_ctrl,
    output cle_pkg::t_dp_stat                o_stat,
    input  logic [cle_pkg::CMD_W-1:0]        i_cmd,
    input  logic [cle_pkg::RANK_W-1:0]       i_card_rank,
    input  logic [cle_pkg::SUIT_W-1:0]       i_card_suit,
    input  logic                             i_rsp_ready,
    output logic                             o_rsp_valid,
    output logic [cle_pkg::RANK_W-1:0]       o_popped_rank,
    output logic [cle_pkg::SUIT_W-1:0]       o_front_suit,
    output logic [cle_pkg::CNT_OUT_W-1:0]    o_suit_total,
    output logic [cle_pkg::CNT_OUT_W-1:0]    o_list_length,
    output logic [cle_pkg::STATUS_W-1:0]     o_status
);

    localparam int AW = $clog2(DECK_DEPTH);
    localparam int CW = $clog2(DECK_DEPTH + 1);
    localparam int OW = cle_pkg::CNT_OUT_W;
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DECK_DEPTH);
    localparam logic [AW-1:0] LAST_A   = AW'(DECK_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DECK_DEPTH);

    logic [cle_pkg::CARD_W-1:0] mem [DECK_DEPTH];

    logic [AW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_occ, n_occ;
    logic [CW-1:0]                r_idx;
    logic [CW-1:0]                r_total;
    logic                         r_found;
    logic [AW-1:0]                r_rd_addr;
    logic [AW-1:0]                r_prev_addr;
    logic [cle_pkg::CARD_W-1:0]   r_rd_data;
    logic [cle_pkg::CMD_W-1:0]    r_cmd;
    logic [cle_pkg::CARD_W-1:0]   r_card;
    logic [cle_pkg::RANK_W-1:0]   r_pop_rank;
    logic [cle_pkg::SUIT_W-1:0]   r_pop_suit;
    cle_pkg::t_status             r_status;
    logic                         r_out_valid;

    logic                         w_full;
    logic                         w_empty;
    logic [AW-1:0]                w_head_dec;
    logic [AW-1:0]                w_head_inc;
    logic [AW-1:0]                w_tail_addr;
    logic [AW-1:0]                w_scan_addr;
    logic                         w_match;
    logic                         w_suit_hit;
    logic                         w_scan_last;
    logic                         w_is_push;
    logic                         w_is_append;
    logic                         w_is_pop;
    logic                         w_is_remove;
    logic                         w_is_count;
    logic                         w_rd_en;
    logic [AW-1:0]                w_rd_addr;
    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [cle_pkg::CARD_W-1:0]   w_wr_data;
    logic [CW+OW-1:0]             w_total_ext;
    logic [CW+OW-1:0]             w_occ_ext;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign w_full      = (r_occ == DEPTH_C);
    assign w_empty     = (r_occ == '0);
    assign w_head_dec  = (r_head == '0) ? LAST_A : r_head - 1'b1;
    assign w_head_inc  = (r_head == LAST_A) ? '0 : r_head + 1'b1;
    assign w_tail_addr = f_phys(r_head, r_occ[AW-1:0]);
    assign w_scan_addr = f_phys(r_head, r_idx[AW-1:0]);
    assign w_match     = (r_rd_data == r_card);
    assign w_suit_hit  = (r_rd_data[cle_pkg::SUIT_W-1:0] == r_card[cle_pkg::SUIT_W-1:0]);
    assign w_scan_last = (({1'b0, r_idx} + 1'b1) == {1'b0, r_occ});

    assign w_is_push   = (r_cmd == cle_pkg::CMD_PUSH);
    assign w_is_append = (r_cmd == cle_pkg::CMD_APPEND);
    assign w_is_pop    = (r_cmd == cle_pkg::CMD_POP);
    assign w_is_remove = (r_cmd == cle_pkg::CMD_REMOVE);
    assign w_is_count  = (r_cmd == cle_pkg::CMD_COUNT);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_scan_addr;
        w_wr_en   = 1'b0;
        w_wr_addr = w_tail_addr;
        w_wr_data = r_card;
        if (i_ctrl.exec && w_is_pop) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_head;
        end else if (i_ctrl.scan_rd) begin
            w_rd_en = 1'b1;
        end
        if (i_ctrl.exec && w_is_push && !w_full) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_head_dec;
        end else if (i_ctrl.exec && w_is_append && !w_full) begin
            w_wr_en = 1'b1;
        end else if (i_ctrl.scan_chk && w_is_remove && r_found) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_prev_addr;
            w_wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_head = r_head;
        n_occ  = r_occ;
        if (i_ctrl.exec && !w_full && (w_is_push || w_is_append)) begin
            n_occ = r_occ + 1'b1;
            if (w_is_push) begin
                n_head = w_head_dec;
            end
        end
        if (i_ctrl.pop_take) begin
            n_head = w_head_inc;
            n_occ  = r_occ - 1'b1;
        end
        if (i_ctrl.scan_chk && w_scan_last && w_is_remove && (r_found || w_match)) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd      <= i_cmd;
            r_card     <= {i_card_rank, i_card_suit};
            r_idx      <= '0;
            r_total    <= '0;
            r_found    <= 1'b0;
            r_pop_rank <= '0;
            r_pop_suit <= '0;
            r_status   <= cle_pkg::ST_OK;
        end
        if (i_ctrl.exec) begin
            if ((w_is_push || w_is_append) && w_full) begin
                r_status <= cle_pkg::ST_FULL;
            end else if (w_is_pop && w_empty) begin
                r_status <= cle_pkg::ST_EMPTY;
            end
        end
        if (i_ctrl.pop_take) begin
            r_pop_rank <= r_rd_data[cle_pkg::CARD_W-1:cle_pkg::SUIT_W];
            r_pop_suit <= r_rd_data[cle_pkg::SUIT_W-1:0];
        end
        if (i_ctrl.scan_rd) begin
            r_rd_addr <= w_scan_addr;
        end
        if (i_ctrl.scan_chk) begin
            r_idx       <= r_idx + 1'b1;
            r_prev_addr <= r_rd_addr;
            if (w_is_count && w_suit_hit) begin
                r_total <= r_total + 1'b1;
            end
            if (w_is_remove && w_match) begin
                r_found <= 1'b1;
            end
        end
    end

    assign w_total_ext = {{OW{1'b0}}, r_total};
    assign w_occ_ext   = {{OW{1'b0}}, r_occ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            o_popped_rank <= r_pop_rank;
            o_front_suit  <= r_pop_suit;
            o_suit_total  <= w_total_ext[OW-1:0];
            o_list_length <= w_occ_ext[OW-1:0];
            o_status      <= r_status;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_stat.cmd       = r_cmd;
    assign o_stat.full      = w_full;
    assign o_stat.empty     = w_empty;
    assign o_stat.scan_last = w_scan_last;
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

endmodule

>>> rtl/core/card_list_engine.sv
// Steps: each command passes the idle, execute and result states; a pop on a non-empty
// list adds a pop state, and a remove or count on a non-empty list adds a read and a check
// state per stored card. One command at a time; the next is taken the cycle after its
// result is registered.
// A result still waiting on ready holds the next result, and so the next command, back.
// Reset: synchronous, active low; empties the list at once, store contents stay undefined.
// ----------------------------------------------------------------------------
// Card list engine
// Ordered list of cards with push, append, pop, keyed remove and suit count.
// ----------------------------------------------------------------------------
module card_list_engine #(
    parameter int DECK_DEPTH = cle_pkg::DECK_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cle_cmd_if.sink  i_cmd,
    cle_rsp_if.source o_rsp
);

    cle_pkg::t_dp_ctrl w_ctrl;
    cle_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    assign i_cmd.ready = w_in_ready;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    cle_datapath #(
        .DECK_DEPTH (DECK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_cmd         (i_cmd.cmd),
        .i_card_rank   (i_cmd.card_rank),
        .i_card_suit   (i_cmd.card_suit),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_popped_rank (o_rsp.popped_rank),
        .o_front_suit  (o_rsp.front_suit),
        .o_suit_total  (o_rsp.suit_total),
        .o_list_length (o_rsp.list_length),
        .o_status      (o_rsp.status)
    );

endmodule

>>> rtl/core/cle_checker.sv
// ----------------------------------------------------------------------------
// Card list engine checker
// Port-level assertions on transfers, status codes and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_checker #(
    parameter int DECK_DEPTH = cle_pkg::DECK_DEPTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [cle_pkg::RANK_W-1:0]         i_popped_rank,
    input logic [cle_pkg::SUIT_W-1:0]         i_front_suit,
    input logic [cle_pkg::CNT_OUT_W-1:0]      i_suit_total,
    input logic [cle_pkg::CNT_OUT_W-1:0]      i_list_length,
    input logic [cle_pkg::STATUS_W-1:0]       i_status
);

    localparam logic [cle_pkg::CNT_OUT_W-1:0] DEPTH_LEN = cle_pkg::CNT_OUT_W'(DECK_DEPTH);

    `CLE_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    `CLE_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    `CLE_ASSERT(a_empty_pop, i_clk, i_rst_n, i_out_valid && i_status == cle_pkg::ST_EMPTY |-> i_list_length == '0 && i_popped_rank == '0 && i_front_suit == '0)

    `CLE_ASSERT(a_full_insert, i_clk, i_rst_n, i_out_valid && i_status == cle_pkg::ST_FULL |-> i_list_length == DEPTH_LEN && i_suit_total == '0)

    `CLE_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_list_length) && $stable(i_popped_rank))

endmodule

bind card_list_engine cle_checker #(
    .DECK_DEPTH (DECK_DEPTH)
) u_cle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_popped_rank (o_rsp.popped_rank),
    .i_front_suit  (o_rsp.front_suit),
    .i_suit_total  (o_rsp.suit_total),
    .i_list_length (o_rsp.list_length),
    .i_status      (o_rsp.status)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Card list engine testbench
// Drives push, append, pop, remove, count and unknown commands through the command
// channel, predicts every response from a queue model of the deck, and
// compares each response transfer field by field, under three idling mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DECK_DEPTH   = cle_pkg::DECK_DEPTH_DEF;
    localparam int CMD_W        = cle_pkg::CMD_W;
    localparam int RANK_W       = cle_pkg::RANK_W;
    localparam int SUIT_W       = cle_pkg::SUIT_W;
    localparam int CARD_W       = cle_pkg::CARD_W;
    localparam int CNT_OUT_W    = cle_pkg::CNT_OUT_W;
    localparam int CMD_CODE_MAX = (1 << CMD_W) - 1;
    localparam int RANK_MAX     = (1 << RANK_W) - 1;
    localparam int SUIT_MAX     = (1 << SUIT_W) - 1;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
    } t_card_cmd;

    typedef struct packed {
        logic [RANK_W-1:0]    rank;
        logic [SUIT_W-1:0]    suit;
        logic [CNT_OUT_W-1:0] total;
        logic [CNT_OUT_W-1:0] length;
        cle_pkg::t_status     status;
    } t_card_result;

    typedef enum int { BURST_FILL, BURST_MIX, BURST_DRAIN } t_burst_kind;

    logic i_clk;
    logic i_rst_n;

    cle_cmd_if cmd_ch();
    cle_rsp_if rsp_ch();

    card_list_engine #(.DECK_DEPTH(DECK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_card_cmd         card_cmds_pending[$];
    t_card_result      card_results_due[$];
    logic [CARD_W-1:0] deck_model[$];

    int send_idle_pct;
    int recv_idle_pct;
    int failures;
    int cmds_sent;
    int results_seen;
    int full_hits;
    int empty_hits;
    int removes_hit;
    int deepest;

    always #5 i_clk = ~i_clk;

    function automatic t_card_result predict_card_command(logic [CMD_W-1:0] cmd,
                                                          logic [RANK_W-1:0] rank,
                                                          logic [SUIT_W-1:0] suit);
        t_card_result      res;
        logic [CARD_W-1:0] card;
        logic [CARD_W-1:0] front;
        int                total;
        res   = '0;
        card  = {rank, suit};
        total = 0;
        case (cmd) inside
            cle_pkg::CMD_PUSH, cle_pkg::CMD_APPEND: begin
                if (deck_model.size() >= DECK_DEPTH) begin
                    res.status = cle_pkg::ST_FULL;
                    full_hits++;
                end else if (cmd == cle_pkg::CMD_PUSH) begin
                    deck_model.push_front(card);
                end else begin
                    deck_model.push_back(card);
                end
            end
            cle_pkg::CMD_POP: begin
                if (deck_model.size() == 0) begin
                    res.status = cle_pkg::ST_EMPTY;
                    empty_hits++;
                end else begin
                    front    = deck_model.pop_front();
                    res.rank = front[CARD_W-1:SUIT_W];
                    res.suit = front[SUIT_W-1:0];
                end
            end
            cle_pkg::CMD_REMOVE: begin
                for (int i = 0; i < deck_model.size(); i++) begin
                    if (deck_model[i] == card) begin
                        deck_model.delete(i);
                        removes_hit++;
                        break;
                    end
                end
            end
            cle_pkg::CMD_COUNT: begin
                foreach (deck_model[i]) begin
                    if (deck_model[i][SUIT_W-1:0] == suit) total++;
                end
                res.total = CNT_OUT_W'(total);
            end
            default: ;
        endcase
        res.length = CNT_OUT_W'(deck_model.size());
        if (deck_model.size() > deepest) deepest = deck_model.size();
        return res;
    endfunction

    task automatic queue_card_cmd(logic [CMD_W-1:0] cmd, int rank, int suit);
        t_card_cmd item;
        item.cmd  = cmd;
        item.rank = RANK_W'(rank);
        item.suit = SUIT_W'(suit);
        card_cmds_pending.push_back(item);
    endtask

    function automatic int pick_rank(int hi);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, RANK_MAX);
        return $urandom_range(1, hi);
    endfunction

    task automatic queue_burst(t_burst_kind kind, int n);
        int               r;
        int               hi;
        logic [CMD_W-1:0] c;
        hi = ($urandom_range(0, 1) == 0) ? 3 : 13;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            case (kind)
                BURST_FILL:
                    c = r < 45 ? cle_pkg::CMD_PUSH : r < 88 ? cle_pkg::CMD_APPEND :
                        r < 93 ? cle_pkg::CMD_REMOVE : r < 97 ? cle_pkg::CMD_COUNT :
                        cle_pkg::CMD_POP;
                BURST_DRAIN:
                    c = r < 45 ? cle_pkg::CMD_POP : r < 85 ? cle_pkg::CMD_REMOVE :
                        r < 93 ? cle_pkg::CMD_COUNT : r < 97 ? cle_pkg::CMD_PUSH :
                        cle_pkg::CMD_APPEND;
                default:
                    c = r < 20 ? cle_pkg::CMD_PUSH : r < 40 ? cle_pkg::CMD_APPEND :
                        r < 60 ? cle_pkg::CMD_POP : r < 78 ? cle_pkg::CMD_REMOVE :
                        r < 96 ? cle_pkg::CMD_COUNT :
                        CMD_W'($urandom_range(cle_pkg::CMD_COUNT + 1, CMD_CODE_MAX));
            endcase
            queue_card_cmd(c, pick_rank(hi), $urandom_range(0, SUIT_MAX));
        end
    endtask

    task automatic wait_drained();
        while (card_cmds_pending.size() != 0 || cmd_ch.valid || card_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_failure(string what, t_card_result exp, t_card_result got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected rank %0d suit %0d total %0d length %0d status %0d,",
                     $realtime, what, exp.rank, exp.suit, exp.total, exp.length, exp.status,
                     " got rank %0d suit %0d total %0d length %0d status %0d",
                     got.rank, got.suit, got.total, got.length, got.status);
    endtask

    // Command driver: a new transfer is offered only once the previous one is taken.
    always @(posedge i_clk) begin
        t_card_cmd item;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                card_results_due.push_back(
                    predict_card_command(cmd_ch.cmd, cmd_ch.card_rank, cmd_ch.card_suit));
                cmds_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (card_cmds_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item = card_cmds_pending.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.cmd       <= item.cmd;
                    cmd_ch.card_rank <= item.rank;
                    cmd_ch.card_suit <= item.suit;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with a randomly stalling ready.
    always @(posedge i_clk) begin
        t_card_result got;
        t_card_result exp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.popped_rank, rsp_ch.front_suit, rsp_ch.suit_total,
                       rsp_ch.list_length, cle_pkg::t_status'(rsp_ch.status)};
                results_seen++;
                if (card_results_due.size() == 0) begin
                    report_failure("response with no command outstanding", '0, got);
                end else begin
                    exp = card_results_due.pop_front();
                    if (got.rank !== exp.rank || got.suit !== exp.suit ||
                        got.total !== exp.total || got.length !== exp.length ||
                        got.status !== exp.status)
                        report_failure("response mismatch", exp, got);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        int queued;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = cle_pkg::CMD_PUSH;
        cmd_ch.card_rank = '0;
        cmd_ch.card_suit = '0;
        rsp_ch.ready     = 1'b0;
        send_idle_pct    = 17;
        recv_idle_pct    = 77;
        failures         = 0;
        cmds_sent        = 0;
        results_seen     = 0;
        full_hits        = 0;
        empty_hits       = 0;
        removes_hit      = 0;
        deepest          = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list behavior, unknown codes, out-of-range ranks, duplicate removal.
        queue_card_cmd(cle_pkg::CMD_POP, 1, 0);
        queue_card_cmd(cle_pkg::CMD_COUNT, 1, 0);
        queue_card_cmd(cle_pkg::CMD_REMOVE, 5, 1);
        for (int c = cle_pkg::CMD_COUNT + 1; c <= CMD_CODE_MAX; c++)
            queue_card_cmd(CMD_W'(c), $urandom_range(0, RANK_MAX), $urandom_range(0, SUIT_MAX));
        queue_card_cmd(cle_pkg::CMD_PUSH, 1, 0);
        queue_card_cmd(cle_pkg::CMD_APPEND, 13, SUIT_MAX);
        queue_card_cmd(cle_pkg::CMD_PUSH, 0, 2);
        queue_card_cmd(cle_pkg::CMD_APPEND, RANK_MAX, 1);
        queue_card_cmd(cle_pkg::CMD_APPEND, 1, 0);
        queue_card_cmd(cle_pkg::CMD_COUNT, 13, 0);
        queue_card_cmd(cle_pkg::CMD_COUNT, 1, SUIT_MAX);
        queue_card_cmd(cle_pkg::CMD_REMOVE, 1, 0);
        queue_card_cmd(cle_pkg::CMD_REMOVE, 7, 2);
        queue_card_cmd(cle_pkg::CMD_REMOVE, RANK_MAX, 1);
        queue_card_cmd(cle_pkg::CMD_COUNT, 1, 0);
        queue_card_cmd(CMD_W'(CMD_CODE_MAX), 1, 0);
        repeat (4) queue_card_cmd(cle_pkg::CMD_POP, 1, 0);

        for (int phase = 0; phase < 3; phase++) begin
            queued = 0;
            while (queued < 300) begin
                int n_fill, n_mix, n_drain;
                n_fill  = $urandom_range(70, 100);
                n_mix   = $urandom_range(20, 50);
                n_drain = $urandom_range(70, 100);
                queue_burst(BURST_FILL, n_fill);
                queue_burst(BURST_MIX, n_mix);
                queue_burst(BURST_DRAIN, n_drain);
                queued += n_fill + n_mix + n_drain;
            end
            wait_drained();
            if (phase == 0) begin
                send_idle_pct = 77;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        repeat (2 * DECK_DEPTH + 8) @(posedge i_clk);
        $display("Ran %0d commands and checked %0d responses; deepest list %0d cards.",
                 cmds_sent, results_seen, deepest);
        $display("Inserts refused on a full list: %0d, pops on an empty list: %0d, %s%0d.",
                 full_hits, empty_hits, "removes that found their card: ", removes_hit);
        if (failures == 0 && card_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d responses never arrived",
                     failures, card_results_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #15ms;
        $display("Timed out with %0d responses outstanding", card_results_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
